// ===== rtl/ppsch_pkg.sv =====
// Package for the preemptive priority scheduler.
// Holds the fixed field widths, request kinds, status codes and sequencer states.
// No dependencies.
package ppsch_pkg;

  localparam int unsigned ID_W      = 4;
  localparam int unsigned PRIO_IN_W = 8;
  localparam int unsigned BURST_W   = 16;
  localparam int unsigned OUT_T_W   = 16;
  localparam int unsigned STAT_W    = 2;

  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BUSY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

endpackage

// ===== rtl/ppsch_slot_ram.sv =====
// Slot table memory of the scheduler: one write port, one registered read port.
// Stores the packed priority, arrival, remaining and burst of every slot.
// Depends on nothing.
module ppsch_slot_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned IDX_W  = 4,
  parameter int unsigned DATA_W = 56
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [IDX_W-1:0]  raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ppsch_cmp.sv =====
// Shared compare unit of the scheduler: decides whether a candidate slot beats
// the best slot seen so far by priority, then age, then remaining burst.
// Depends on ppsch_pkg.
module ppsch_cmp
  import ppsch_pkg::*;
#(
  parameter int unsigned TIME_BITS     = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic [TIME_BITS-1:0]     now_i,
  input  logic [PRIORITY_BITS-1:0] cand_prio_i,
  input  logic [TIME_BITS-1:0]     cand_arr_i,
  input  logic [BURST_W-1:0]       cand_rem_i,
  input  logic [PRIORITY_BITS-1:0] best_prio_i,
  input  logic [TIME_BITS-1:0]     best_age_i,
  input  logic [BURST_W-1:0]       best_rem_i,
  output logic [TIME_BITS-1:0]     cand_age_o,
  output logic                     wins_o
);

  always_comb begin
    cand_age_o = now_i - cand_arr_i;
    if (cand_prio_i != best_prio_i) begin
      wins_o = cand_prio_i < best_prio_i;
    end else if (cand_age_o != best_age_i) begin
      wins_o = cand_age_o > best_age_i;
    end else begin
      wins_o = cand_rem_i < best_rem_i;
    end
  end

endmodule

// ===== rtl/preemptive_priority_scheduler.sv =====
// Top level of the tick-driven preemptive priority scheduler.
// Sequencer, slot valid bits, time counter and result register; uses
// ppsch_pkg, ppsch_slot_ram and ppsch_cmp.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid_i, in_stall_o | kind_i, task_id_i, task_priority_i,
//           |                        | burst_length_i
//  output   | out_valid_o,out_stall_i| running_valid_o, running_task_o, finished_o,
//           |                        | turnaround_o, waiting_o, status_o
//
// An arrive request goes straight from idle to the final step; a tick request
// scans the table, reading one slot a cycle through its single read port and
// the shared compare unit. Reset clears the valid bits, time and sequencer.
// A request is taken while an earlier result still waits in the output register;
// the final step waits until that result is taken.
module preemptive_priority_scheduler
  import ppsch_pkg::*;
#(
  parameter int unsigned SLOTS         = 16,
  parameter int unsigned TIME_BITS     = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 kind_i,
  input  logic [ID_W-1:0]      task_id_i,
  input  logic [PRIO_IN_W-1:0] task_priority_i,
  input  logic [BURST_W-1:0]   burst_length_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 running_valid_o,
  output logic [ID_W-1:0]      running_task_o,
  output logic                 finished_o,
  output logic [OUT_T_W-1:0]   turnaround_o,
  output logic [OUT_T_W-1:0]   waiting_o,
  output logic [STAT_W-1:0]    status_o
);

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned DATA_W = PRIORITY_BITS + TIME_BITS + 2 * BURST_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_e state_q, state_d;

  logic                     kind_q;
  logic [ID_W-1:0]          id_q;
  logic [PRIORITY_BITS-1:0] prio_q;
  logic [BURST_W-1:0]       burst_q;

  logic [SLOTS-1:0]     slot_valid_q;
  logic [TIME_BITS-1:0] time_q;
  logic [IDX_W-1:0]     cnt_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic                 rd_act_q;

  logic                     best_found_q;
  logic [IDX_W-1:0]         best_idx_q;
  logic [PRIORITY_BITS-1:0] best_prio_q;
  logic [TIME_BITS-1:0]     best_age_q;
  logic [TIME_BITS-1:0]     best_arr_q;
  logic [BURST_W-1:0]       best_rem_q;
  logic [BURST_W-1:0]       best_burst_q;

  logic                 out_valid_q;
  logic                 run_vld_q;
  logic [ID_W-1:0]      run_task_q;
  logic                 fin_q;
  logic [OUT_T_W-1:0]   tat_q;
  logic [OUT_T_W-1:0]   wait_q;
  logic [STAT_W-1:0]    status_q;

  logic                     in_accept;
  logic                     out_free;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic                     ram_re;
  logic [DATA_W-1:0]        ram_rdata;
  logic [PRIORITY_BITS-1:0] cand_prio;
  logic [TIME_BITS-1:0]     cand_arr;
  logic [BURST_W-1:0]       cand_rem;
  logic [BURST_W-1:0]       cand_burst;
  logic [TIME_BITS-1:0]     cand_age;
  logic                     cand_wins;
  logic                     take_cand;

  logic                 finish_go;
  logic                 arr_ok;
  logic [STAT_W-1:0]    arr_status;
  logic [BURST_W-1:0]   new_rem;
  logic                 done_now;
  logic [TIME_BITS-1:0] time_next;
  logic [TIME_BITS-1:0] tat_full;
  logic [OUT_T_W-1:0]   tat16;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign finish_go = (state_q == ST_FINISH) && out_free;

  assign {cand_prio, cand_arr, cand_rem, cand_burst} = ram_rdata;

  ppsch_slot_ram #(
    .DEPTH (SLOTS),
    .IDX_W (IDX_W),
    .DATA_W(DATA_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(cnt_q),
    .rdata_o(ram_rdata)
  );

  ppsch_cmp #(
    .TIME_BITS    (TIME_BITS),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_cmp (
    .now_i      (time_q),
    .cand_prio_i(cand_prio),
    .cand_arr_i (cand_arr),
    .cand_rem_i (cand_rem),
    .best_prio_i(best_prio_q),
    .best_age_i (best_age_q),
    .best_rem_i (best_rem_q),
    .cand_age_o (cand_age),
    .wins_o     (cand_wins)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (kind_i == KIND_TICK) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (cnt_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_re    = (state_q == ST_SCAN);
    take_cand = rd_act_q && slot_valid_q[rd_idx_q] && (!best_found_q || cand_wins);

    if ((32'(id_q) >= SLOTS) || slot_valid_q[IDX_W'(id_q)]) begin
      arr_status = STAT_BUSY;
    end else if (burst_q == '0) begin
      arr_status = STAT_ZERO;
    end else begin
      arr_status = STAT_OK;
    end
    arr_ok = (arr_status == STAT_OK);

    new_rem   = best_rem_q - 1'b1;
    done_now  = best_found_q && (new_rem == '0);
    time_next = time_q + 1'b1;
    tat_full  = time_next - best_arr_q;
    tat16     = OUT_T_W'(tat_full);

    ram_we    = 1'b0;
    ram_waddr = IDX_W'(id_q);
    ram_wdata = {prio_q, time_q, burst_q, burst_q};
    if (finish_go) begin
      if (kind_q == KIND_ARRIVE) begin
        ram_we = arr_ok;
      end else begin
        ram_we    = best_found_q;
        ram_waddr = best_idx_q;
        ram_wdata = {best_prio_q, best_arr_q, new_rem, best_burst_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slot_valid_q <= '0;
      time_q       <= '0;
      cnt_q        <= '0;
      rd_act_q     <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_act_q <= (state_q == ST_SCAN);
      if (in_accept) begin
        cnt_q        <= '0;
        best_found_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (take_cand) begin
        best_found_q <= 1'b1;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (finish_go) begin
        out_valid_q <= 1'b1;
        if (kind_q == KIND_ARRIVE) begin
          if (arr_ok) begin
            slot_valid_q[IDX_W'(id_q)] <= 1'b1;
          end
        end else begin
          time_q <= time_next;
          if (done_now) begin
            slot_valid_q[best_idx_q] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (in_accept) begin
      kind_q  <= kind_i;
      id_q    <= task_id_i;
      prio_q  <= PRIORITY_BITS'(task_priority_i);
      burst_q <= burst_length_i;
    end
    if (take_cand) begin
      best_idx_q   <= rd_idx_q;
      best_prio_q  <= cand_prio;
      best_age_q   <= cand_age;
      best_arr_q   <= cand_arr;
      best_rem_q   <= cand_rem;
      best_burst_q <= cand_burst;
    end
    if (finish_go) begin
      if (kind_q == KIND_ARRIVE) begin
        run_vld_q  <= 1'b0;
        run_task_q <= '0;
        fin_q      <= 1'b0;
        tat_q      <= '0;
        wait_q     <= '0;
        status_q   <= arr_status;
      end else begin
        run_vld_q  <= best_found_q;
        run_task_q <= best_found_q ? ID_W'(best_idx_q) : '0;
        fin_q      <= done_now;
        tat_q      <= done_now ? tat16 : '0;
        wait_q     <= done_now ? (tat16 - best_burst_q) : '0;
        status_q   <= STAT_OK;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign running_valid_o = run_vld_q;
  assign running_task_o  = run_task_q;
  assign finished_o      = fin_q;
  assign turnaround_o    = tat_q;
  assign waiting_o       = wait_q;
  assign status_o        = status_q;

endmodule
